// File: hw/rtl/jvcirpe_pkg.sv
// Shared types and constants of the infrared pulse-distance frame encoder.
// Holds the field widths, register indexes and controller/datapath structs.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package jvcirpe_pkg;

    localparam int PAYLOAD_W   = 32;
    localparam int BIT_COUNT_W = 6;
    localparam int DUR_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int MAX_BITS    = 32;
    localparam int LIMIT_BITS  = (MAX_BITS < PAYLOAD_W) ? MAX_BITS : PAYLOAD_W;
    localparam int BIT_IDX_W   = $clog2(PAYLOAD_W);
    localparam int S_TDATA_W   = ((PAYLOAD_W + BIT_COUNT_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((2 * DUR_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER_MARK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SPACE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE   = 3'd4;

    localparam logic [DUR_W-1:0] RST_HEADER_MARK  = 16'd8000;
    localparam logic [DUR_W-1:0] RST_HEADER_SPACE = 16'd4000;
    localparam logic [DUR_W-1:0] RST_BIT_MARK     = 16'd600;
    localparam logic [DUR_W-1:0] RST_ONE_SPACE    = 16'd1600;
    localparam logic [DUR_W-1:0] RST_ZERO_SPACE   = 16'd550;

    typedef struct packed {
        logic load;
        logic emit_header;
        logic emit_bit;
        logic emit_stop;
    } cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic out_free;
    } status_t;

endpackage

// File: hw/rtl/jvcirpe_ctrl.sv
// Frame sequencer of the infrared pulse-distance encoder.
// Steps through header, data bits and stop symbol; drives the datapath commands.
// Depends on jvcirpe_pkg.
`timescale 1ns / 1ps

module jvcirpe_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic                 is_repeat,
    input  jvcirpe_pkg::status_t status,
    output jvcirpe_pkg::cmd_t    cmd
);
    import jvcirpe_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_HEADER = 3'b010,
        ST_BODY   = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        s_axis_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = is_repeat ? ST_BODY : ST_HEADER;
                end
            end
            ST_HEADER:
            begin
                if (status.out_free)
                begin
                    cmd.emit_header = 1'b1;
                    state_next      = ST_BODY;
                end
            end
            ST_BODY:
            begin
                if (status.out_free)
                begin
                    if (status.cnt_zero)
                    begin
                        cmd.emit_stop = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        cmd.emit_bit = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_header || cmd.emit_bit || cmd.emit_stop) |-> status.out_free)
        else $error("symbol emitted while the output register was occupied");

    a_bit_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_bit |-> !status.cnt_zero)
        else $error("data bit emitted with no bits left");

    a_load_starts_frame: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg != ST_IDLE))
        else $error("accepted request did not start a frame");

    a_stop_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_stop |=> (state_reg == ST_IDLE))
        else $error("frame did not end after the stop symbol");

endmodule

// File: hw/rtl/jvcirpe_dp.sv
// Datapath of the infrared pulse-distance encoder.
// Holds the timing registers, the request payload and bit count, and the output register.
// Depends on jvcirpe_pkg.
`timescale 1ns / 1ps

module jvcirpe_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [jvcirpe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [jvcirpe_pkg::DUR_W-1:0]        cfg_data,
    input  logic [jvcirpe_pkg::PAYLOAD_W-1:0]    payload,
    input  logic [jvcirpe_pkg::BIT_COUNT_W-1:0]  bit_count,
    input  jvcirpe_pkg::cmd_t                    cmd,
    output jvcirpe_pkg::status_t                 status,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [jvcirpe_pkg::DUR_W-1:0]        mark_us,
    output logic [jvcirpe_pkg::DUR_W-1:0]        space_us,
    output logic                                 last
);
    import jvcirpe_pkg::*;

    logic [DUR_W-1:0]       header_mark_reg;
    logic [DUR_W-1:0]       header_space_reg;
    logic [DUR_W-1:0]       bit_mark_reg;
    logic [DUR_W-1:0]       one_space_reg;
    logic [DUR_W-1:0]       zero_space_reg;
    logic [PAYLOAD_W-1:0]   data_reg;
    logic [BIT_COUNT_W-1:0] cnt_reg;
    logic [BIT_COUNT_W-1:0] cnt_next;
    logic [BIT_COUNT_W-1:0] cnt_dec;
    logic [BIT_COUNT_W-1:0] cnt_sat;
    logic [BIT_IDX_W-1:0]   bit_idx;
    logic                   m_valid_reg;
    logic [DUR_W-1:0]       mark_reg;
    logic [DUR_W-1:0]       space_reg;
    logic                   last_reg;
    logic                   emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_mark_reg  <= RST_HEADER_MARK;
            header_space_reg <= RST_HEADER_SPACE;
            bit_mark_reg     <= RST_BIT_MARK;
            one_space_reg    <= RST_ONE_SPACE;
            zero_space_reg   <= RST_ZERO_SPACE;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_HEADER_MARK:  header_mark_reg  <= cfg_data;
                REG_HEADER_SPACE: header_space_reg <= cfg_data;
                REG_BIT_MARK:     bit_mark_reg     <= cfg_data;
                REG_ONE_SPACE:    one_space_reg    <= cfg_data;
                REG_ZERO_SPACE:   zero_space_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Counts above the limit are clipped so that a frame never exceeds the payload.
    assign cnt_sat = (bit_count > BIT_COUNT_W'(LIMIT_BITS)) ? BIT_COUNT_W'(LIMIT_BITS)
                                                           : bit_count;
    assign cnt_dec = cnt_reg - BIT_COUNT_W'(1);
    assign bit_idx = cnt_dec[BIT_IDX_W-1:0];
    assign emit    = cmd.emit_header | cmd.emit_bit | cmd.emit_stop;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            cnt_next = cnt_sat;
        end
        else if (cmd.emit_bit)
        begin
            cnt_next = cnt_dec;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        if (cmd.load)
        begin
            data_reg <= payload;
        end
        if (emit)
        begin
            last_reg <= cmd.emit_stop;
            if (cmd.emit_header)
            begin
                mark_reg  <= header_mark_reg;
                space_reg <= header_space_reg;
            end
            else if (cmd.emit_bit)
            begin
                mark_reg  <= bit_mark_reg;
                space_reg <= data_reg[bit_idx] ? one_space_reg : zero_space_reg;
            end
            else
            begin
                mark_reg  <= bit_mark_reg;
                space_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_ready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    assign status.cnt_zero = (cnt_reg == '0);
    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign mark_us         = mark_reg;
    assign space_us        = space_reg;
    assign last            = last_reg;

endmodule

// File: hw/rtl/jvc_ir_pulse_encoder_core.sv
// Top level of the infrared pulse-distance frame encoder.
// Joins the frame sequencer and the datapath to the stream and configuration ports.
// Depends on jvcirpe_pkg, jvcirpe_ctrl and jvcirpe_dp.
`timescale 1ns / 1ps

// One request beat yields a frame of symbol beats: a header symbol unless the
// request is a repeat, one symbol per data bit with the most significant bit
// first, and a stop symbol flagged by tlast; the bit count is clipped to 32.
// The sequencer hands one symbol a cycle to the output register while that
// register is free or being taken, and back-pressure holds it. A new request
// is taken as soon as the stop symbol has been loaded, even while it waits at
// the output. Timing registers may be written at any time the block is idle;
// writes to unused indexes are ignored.

module jvc_ir_pulse_encoder_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // tdata: payload[31:0], bit_count[37:32], zero fill [39:38].
    input  logic [jvcirpe_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // tuser: is_repeat[0].
    input  logic [0:0]                           s_axis_tuser,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: mark_us[15:0], space_us[31:16].
    output logic [jvcirpe_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    output logic                                 m_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [jvcirpe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [jvcirpe_pkg::DUR_W-1:0]        cfg_data
);
    import jvcirpe_pkg::*;

    cmd_t             cmd;
    status_t          status;
    logic [DUR_W-1:0] mark_us;
    logic [DUR_W-1:0] space_us;

    assign cfg_ready = 1'b1;

    jvcirpe_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .is_repeat     (s_axis_tuser[0]),
        .status        (status),
        .cmd           (cmd)
    );

    jvcirpe_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .payload   (s_axis_tdata[PAYLOAD_W-1:0]),
        .bit_count (s_axis_tdata[PAYLOAD_W+BIT_COUNT_W-1:PAYLOAD_W]),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .mark_us   (mark_us),
        .space_us  (space_us),
        .last      (m_axis_tlast)
    );

    assign m_axis_tdata = M_TDATA_W'({space_us, mark_us});

endmodule

// File: verif/jvcirpe_frame_checker.sv
// Frame checker for the infrared pulse-distance frame encoder.
// Mirrors the timing registers, expands each request beat into its symbols and
// compares them with the output beats. Depends on jvcirpe_pkg only.
`timescale 1ns / 1ps

module jvcirpe_frame_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [jvcirpe_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [0:0]                          s_tuser,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [jvcirpe_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                                m_tlast,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [jvcirpe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [jvcirpe_pkg::DUR_W-1:0]       cfg_data,
    output int                                  mismatches,
    output int                                  symbols_due
);
    import jvcirpe_pkg::*;

    typedef struct packed {
        logic [DUR_W-1:0] mark;
        logic [DUR_W-1:0] space;
        logic             stop;
    } symbol_t;

    logic [DUR_W-1:0] header_mark;
    logic [DUR_W-1:0] header_space;
    logic [DUR_W-1:0] bit_mark;
    logic [DUR_W-1:0] one_space;
    logic [DUR_W-1:0] zero_space;

    symbol_t frame_symbols[$];

    function automatic symbol_t make_symbol(logic [DUR_W-1:0] mark, logic [DUR_W-1:0] space,
                                            logic stop);
        symbol_t sym;
        sym.mark  = mark;
        sym.space = space;
        sym.stop  = stop;
        return sym;
    endfunction

    task automatic encode_frame(input logic [PAYLOAD_W-1:0] payload,
                                input logic [BIT_COUNT_W-1:0] bit_count,
                                input logic is_repeat);
        int n;
        n = int'(bit_count);
        if (n > LIMIT_BITS)
            n = LIMIT_BITS;
        if (!is_repeat)
            frame_symbols.push_back(make_symbol(header_mark, header_space, 1'b0));
        for (int i = n - 1; i >= 0; i--)
        begin
            frame_symbols.push_back(make_symbol(bit_mark,
                                                payload[i[BIT_IDX_W-1:0]] ? one_space
                                                                          : zero_space,
                                                1'b0));
        end
        frame_symbols.push_back(make_symbol(bit_mark, '0, 1'b1));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        symbol_t want;
        symbol_t got;
        if (!rst_n)
        begin
            header_mark  = RST_HEADER_MARK;
            header_space = RST_HEADER_SPACE;
            bit_mark     = RST_BIT_MARK;
            one_space    = RST_ONE_SPACE;
            zero_space   = RST_ZERO_SPACE;
            frame_symbols.delete();
            mismatches   = 0;
            symbols_due  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_HEADER_MARK:  header_mark  = cfg_data;
                    REG_HEADER_SPACE: header_space = cfg_data;
                    REG_BIT_MARK:     bit_mark     = cfg_data;
                    REG_ONE_SPACE:    one_space    = cfg_data;
                    REG_ZERO_SPACE:   zero_space   = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                encode_frame(s_tdata[PAYLOAD_W-1:0],
                             s_tdata[PAYLOAD_W+BIT_COUNT_W-1:PAYLOAD_W], s_tuser[0]);
            if (m_tvalid && m_tready)
            begin
                got = make_symbol(m_tdata[DUR_W-1:0], m_tdata[2*DUR_W-1:DUR_W], m_tlast);
                if (frame_symbols.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected symbol beat: mark %0d space %0d last %0d",
                                 $realtime, got.mark, got.space, got.stop);
                end
                else
                begin
                    want = frame_symbols.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: symbol mismatch: expected mark %0d space %0d ",
                                      "last %0d, got mark %0d space %0d last %0d"},
                                     $realtime, want.mark, want.space, want.stop,
                                     got.mark, got.space, got.stop);
                    end
                end
            end
            symbols_due = frame_symbols.size();
        end
    end

endmodule

// File: verif/tb_top.sv
// Top of the testbench for the infrared pulse-distance frame encoder.
// Drives requests, timing register writes and output back-pressure, and gives
// the verdict. Depends on jvcirpe_pkg, the encoder RTL and jvcirpe_frame_checker.
`timescale 1ns / 1ps

module tb_top;

    import jvcirpe_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_ITEMS  = 76;
    localparam int SETTLE_TICKS = 40;

    logic                 clk;
    logic                 rst_n;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [0:0]           s_axis_tuser;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DUR_W-1:0]     cfg_data;

    int   mismatches;
    int   symbols_due;
    int   quiet_cycles;
    logic no_idle;

    jvc_ir_pulse_encoder_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    jvcirpe_frame_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_axis_tdata),
        .s_tuser     (s_axis_tuser),
        .s_tvalid    (s_axis_tvalid),
        .s_tready    (s_axis_tready),
        .m_tdata     (m_axis_tdata),
        .m_tlast     (m_axis_tlast),
        .m_tvalid    (m_axis_tvalid),
        .m_tready    (m_axis_tready),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .symbols_due (symbols_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!no_idle && $urandom_range(0, 2) == 0)
            begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(20, 60)) @(negedge clk);
            else
                repeat ($urandom_range(0, 12)) @(negedge clk);
        end
    end

    // Each task below is entered and left at a falling edge.
    task automatic send_request(input logic [PAYLOAD_W-1:0] payload,
                                input logic [BIT_COUNT_W-1:0] bit_count,
                                input logic is_repeat);
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        s_axis_tdata  = {{(S_TDATA_W - PAYLOAD_W - BIT_COUNT_W){1'b0}}, bit_count, payload};
        s_axis_tuser  = is_repeat;
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_for_frames();
        s_axis_tvalid = 1'b0;
        while (symbols_due != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [DUR_W-1:0] value);
        cfg_index = index;
        cfg_data  = value;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_timing(input logic [DUR_W-1:0] hdr_mark, input logic [DUR_W-1:0] hdr_space,
                              input logic [DUR_W-1:0] mark, input logic [DUR_W-1:0] one_gap,
                              input logic [DUR_W-1:0] zero_gap);
        wait_for_frames();
        write_reg(REG_HEADER_MARK, hdr_mark);
        write_reg(REG_HEADER_SPACE, hdr_space);
        write_reg(REG_BIT_MARK, mark);
        write_reg(REG_ONE_SPACE, one_gap);
        write_reg(REG_ZERO_SPACE, zero_gap);
        if ($urandom_range(0, 1) == 0)
            write_reg(CFG_IDX_W'($urandom_range(REG_ZERO_SPACE + 1, (1 << CFG_IDX_W) - 1)),
                      DUR_W'($urandom));
        cfg_valid = 1'b0;
    endtask

    function automatic logic [DUR_W-1:0] random_duration();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            default: return DUR_W'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [PAYLOAD_W-1:0]   payload;
        logic [BIT_COUNT_W-1:0] bit_count;
        int                     pick;

        rst_n         = 1'b0;
        no_idle       = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tvalid = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_request(32'h0000_0000, 6'd0, 1'b0);
        send_request(32'hFFFF_FFFF, 6'd0, 1'b1);
        send_request(32'hFFFF_FFFF, 6'd32, 1'b0);
        send_request(32'hFFFF_FFFF, 6'd32, 1'b1);
        send_request(32'h0000_0000, 6'd32, 1'b0);
        send_request(32'hAAAA_AAAA, 6'd32, 1'b0);
        send_request(32'h5555_5555, 6'd32, 1'b1);
        send_request(32'h8000_0000, 6'd32, 1'b0);
        send_request(32'h0000_0001, 6'd1, 1'b0);
        send_request(32'h0000_0000, 6'd1, 1'b1);
        send_request(32'hFFFF_FFFF, 6'd63, 1'b0);
        send_request(32'h1234_5678, 6'd33, 1'b1);
        send_request(32'h0000_FFFF, 6'd16, 1'b0);
        send_request(32'h0000_00A5, 6'd8, 1'b1);

        set_timing('1, '1, '1, '1, '1);
        send_request(32'hFFFF_FFFF, 6'd32, 1'b0);
        send_request(32'h0000_0000, 6'd5, 1'b0);
        send_request(32'h0000_1234, 6'd20, 1'b1);
        send_request(32'h0000_0000, 6'd0, 1'b0);

        set_timing('0, '0, '0, '0, '0);
        send_request(32'hFFFF_FFFF, 6'd32, 1'b0);
        send_request(32'hAAAA_AAAA, 6'd32, 1'b1);
        send_request(32'h0000_0000, 6'd7, 1'b0);
        send_request(32'hF0F0_F0F0, 6'd63, 1'b0);

        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            set_timing(random_duration(), random_duration(), random_duration(),
                       random_duration(), random_duration());
            if (phase == RAND_PHASES - 1)
                no_idle = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 15);
                if (pick == 0)
                    bit_count = '0;
                else if (pick == 1)
                    bit_count = BIT_COUNT_W'($urandom_range(LIMIT_BITS + 1,
                                                            (1 << BIT_COUNT_W) - 1));
                else if (pick < 5)
                    bit_count = BIT_COUNT_W'($urandom_range(1, 4));
                else
                    bit_count = BIT_COUNT_W'($urandom_range(1, LIMIT_BITS));
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    payload = '0;
                else if (pick == 1)
                    payload = '1;
                else
                    payload = $urandom;
                send_request(payload, bit_count, 1'($urandom_range(0, 1)));
                if (!no_idle && $urandom_range(0, 39) == 0)
                    wait_for_frames();
            end
        end

        s_axis_tvalid = 1'b0;
        while (symbols_due != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);

        if (mismatches == 0 && symbols_due == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
